// ===== src/lfdfd_pkg.sv =====
// shared types and constants for the dithered fm divisor block
package lfdfd_pkg;

	localparam int SampleWidth  = 16;
	localparam int DivisorWidth = 24;
	localparam int CfgWidth     = 24;
	localparam int CfgIdxWidth  = 2;
	localparam int OffIntWidth  = 8;
	localparam int OffFracWidth = 32;
	localparam int NoiseWidth   = 32;
	localparam int ProdWidth    = OffIntWidth + OffFracWidth;

	localparam logic [NoiseWidth-1:0] LfsrTaps  = 32'hD000_0001;
	localparam logic [NoiseWidth-1:0] LfsrReset = 32'h0000_0001;

	localparam logic [CfgWidth-1:0] CarrierReset = 24'd26357;
	localparam logic [CfgWidth-1:0] GainReset    = 24'd524288;

	localparam logic [CfgIdxWidth-1:0] CFG_CARRIER = 2'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_GAIN    = 2'd1;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic [OffIntWidth-1:0]  off_int;
		logic [OffFracWidth-1:0] off_frac;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_head_t;

endpackage

// ===== src/lfdfd_front.sv =====
// front end: classifies each input word and scales samples by the gain
module lfdfd_front import lfdfd_pkg::*; (
	input  logic                          kind,
	input  logic signed [SampleWidth-1:0] sample,
	input  logic [CfgWidth-1:0]           gain,
	output entry_t                        entry
);

	logic signed [CfgWidth:0]    gain_s;
	logic signed [ProdWidth-1:0] prod;

	always_comb begin
		gain_s = $signed({1'b0, gain});
		prod = ProdWidth'(sample) * ProdWidth'(gain_s);
		entry.kind = kind;
		if (kind == KIND_SAMPLE) begin
			entry.off_int  = prod[ProdWidth-1:OffFracWidth];
			entry.off_frac = prod[OffFracWidth-1:0];
		end else begin
			entry.off_int  = '0;
			entry.off_frac = '0;
		end
	end

endmodule

// ===== src/lfdfd_queue.sv =====
// two-entry queue between front and back
module lfdfd_queue import lfdfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  push_entry,
	output logic    full,
	input  logic    pop,
	output q_head_t head
);

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign full = count_q[1];
	assign head = {count_q != 2'd0, mem_q[rd_ptr_q]};

endmodule

// ===== src/lfdfd_back.sv =====
// back end: holds the offset, steps the lfsr and forms the divisor word
module lfdfd_back import lfdfd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  q_head_t                 head,
	output logic                    pop,
	input  logic [CfgWidth-1:0]     carrier,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DivisorWidth-1:0] divisor
);

	logic [NoiseWidth-1:0]   noise_q;
	logic [OffIntWidth-1:0]  off_int_q;
	logic [OffFracWidth-1:0] off_frac_q;
	logic                    out_valid_q;
	logic [DivisorWidth-1:0] divisor_q;

	logic                    is_tick;
	logic                    out_free;
	logic [NoiseWidth-1:0]   noise_next;
	logic                    dither;
	logic [DivisorWidth-1:0] sum;

	always_comb begin
		is_tick    = head.entry.kind == KIND_TICK;
		out_free   = !out_valid_q || !out_stall;
		pop        = head.valid && (!is_tick || out_free);
		noise_next = (noise_q >> 1) ^ (noise_q[0] ? LfsrTaps : '0);
		dither     = off_frac_q > noise_next;
		sum        = carrier
			+ {{(DivisorWidth-OffIntWidth){off_int_q[OffIntWidth-1]}}, off_int_q}
			+ DivisorWidth'(dither);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q     <= LfsrReset;
			off_int_q   <= '0;
			off_frac_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && !is_tick) begin
				off_int_q  <= head.entry.off_int;
				off_frac_q <= head.entry.off_frac;
			end
			if (pop && is_tick) begin
				noise_q     <= noise_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_tick) begin
			divisor_q <= sum;
		end
	end

	assign out_valid = out_valid_q;
	assign divisor   = divisor_q;

endmodule

// ===== src/lfsr_dithered_fm_divisor.sv =====
// top level: dithered fm clock divisor generator
// a tick word reaches the divisor output through the queue and then the output register
// throughput: one word per cycle while out_stall is low; the multiply and lfsr step are combinational
// sample words give no output; the two-entry queue lets input and output stall apart
// reset: asynchronous active low; lfsr to one, offsets to zero, config registers to defaults, out_valid low
module lfsr_dithered_fm_divisor import lfdfd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CfgIdxWidth-1:0]        cfg_index,
	input  logic [CfgWidth-1:0]           cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          kind,
	input  logic signed [SampleWidth-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [DivisorWidth-1:0]       divisor
);

	logic [CfgWidth-1:0] carrier_q;
	logic [CfgWidth-1:0] gain_q;
	entry_t              front_entry;
	q_head_t             head;
	logic                q_full;
	logic                q_pop;
	logic                push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_q <= CarrierReset;
			gain_q    <= GainReset;
		end else if (cfg_we) begin
			if (cfg_index == CFG_CARRIER) begin
				carrier_q <= cfg_data;
			end else if (cfg_index == CFG_GAIN) begin
				gain_q <= cfg_data;
			end
		end
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	lfdfd_front u_front (
		.kind   (kind),
		.sample (sample),
		.gain   (gain_q),
		.entry  (front_entry)
	);

	lfdfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head       (head)
	);

	lfdfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (q_pop),
		.carrier   (carrier_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.divisor   (divisor)
	);

endmodule
